>>> src/assert_macros.svh
// Assertion macros shared by the console RTL; define ASSERT_OFF to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed: invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: implication violated");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication violated");

`else

`define ASSERT_ALWAYS(name, expr)
`define ASSERT_IMPLIES(name, ante, cons)
`define ASSERT_NEXT(name, ante, cons)

`endif

`endif

>>> src/tccw_pkg.sv
// Package with request and result types and fixed constants of the text console.
package tccw_pkg;

  // Control characters with their own handling.
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;

  // Request kinds.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Register index of text_attr (bit 2 of the byte address).
  localparam logic REG_TEXT_ATTR = 1'b0;

  // Reset values.
  localparam logic [7:0]  ATTR_RESET = 8'h07;
  localparam logic [15:0] RESET_CELL = 16'h0700;

  // Widths inside the address unit: they cover the request fields and the
  // largest supported screen.
  localparam int unsigned UNIT_RW = 7;
  localparam int unsigned UNIT_CW = 7;
  localparam int unsigned LIN_W   = 14;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } req_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [10:0] cursor_index;
    logic [15:0] cell_value;
  } res_t;

endpackage

>>> src/text_console_char_writer_unit.sv
// Text console: screen store of character cells, cursor and a sequencer around one memory with a read and a write port.
// The block takes one request at a time: it is accepted when start_i is high and busy_o is low,
// and one result appears on res_o for exactly one cycle with res_valid_o high; the receiver
// cannot stall it. After reset the block clears the screen store, one cell a cycle, and is
// busy until all ROWS*COLUMNS cells (2000 by default) are cleared. The screen memory read is
// registered, so a read inside the screen passes through ST_RD and ST_RDW before its result,
// while a read outside it goes straight to the result. A printed character goes through
// ST_PUT, a newline through ST_NL, and a character that wraps the row through both. A newline
// that scrolls the screen copies (ROWS-1)*COLUMNS cells up one row, completes the last copy
// write, then writes one row of blanks; a wrapping character can scroll it the same way.
// A backspace inside a row blanks one cell; at the start of a row it first scans left over
// blank cells, with a read and a check for each cell scanned. After each result the block
// returns to idle before the next request is taken.
// The text_attr register can be written over the APB port at any time the block is idle.
`include "assert_macros.svh"

module text_console_char_writer_unit
  import tccw_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel.
  input  logic        start_i,
  output logic        busy_o,
  input  req_t        req_i,
  // Result channel.
  output logic        res_valid_o,
  output res_t        res_o,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned DEPTH     = ROWS * COLUMNS;
  localparam int unsigned AW        = $clog2(DEPTH);
  localparam int unsigned RW        = $clog2(ROWS);
  localparam int unsigned CW        = $clog2(COLUMNS);
  localparam int unsigned COPY_LAST = (ROWS - 1) * COLUMNS - 1;

  typedef enum logic [13:0] {
    ST_CLEAR  = 14'h0001,
    ST_IDLE   = 14'h0002,
    ST_RD     = 14'h0004,
    ST_RDW    = 14'h0008,
    ST_PUT    = 14'h0010,
    ST_NL     = 14'h0020,
    ST_SCROLL = 14'h0040,
    ST_FLUSH  = 14'h0080,
    ST_BLANK  = 14'h0100,
    ST_BS     = 14'h0200,
    ST_BSR    = 14'h0400,
    ST_BSC    = 14'h0800,
    ST_BSW    = 14'h1000,
    ST_DONE   = 14'h2000
  } state_e;

  state_e          state_q, state_d;
  logic [RW-1:0]   cur_row_q, cur_row_d;
  logic [CW-1:0]   cur_col_q, cur_col_d;
  logic [AW-1:0]   ptr_q, ptr_d;
  logic [7:0]      attr_q;
  req_t            req_q;
  logic [15:0]     cell_q, cell_d;
  logic            wr_pend_q;
  logic [AW-1:0]   wr_addr_q;

  logic            accept;
  logic [15:0]     blank;
  logic            cell_blank;

  // Address unit signals.
  logic [UNIT_RW-1:0] u_row;
  logic [UNIT_CW-1:0] u_col;
  logic [LIN_W-1:0]   u_lin;
  logic [AW-1:0]      u_addr;

  // Memory port signals.
  logic [15:0]     mem_q [DEPTH];
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [15:0]     mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [15:0]     rdata_q;

  assign accept     = start_i && !busy_o;
  assign busy_o     = (state_q != ST_IDLE);
  assign blank      = {attr_q, 8'h00};
  assign cell_blank = (rdata_q == blank);

  // Configuration register write and read-back.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TEXT_ATTR) ? {24'h000000, attr_q} : 32'h0000_0000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TEXT_ATTR)) begin
      attr_q <= pwdata[7:0];
    end
  end

  // Shared address unit: linear cell index of a row and column, for the request or the cursor.
  always_comb begin
    if (state_q == ST_RD) begin
      u_row = UNIT_RW'(req_q.read_row);
      u_col = UNIT_CW'(req_q.read_col);
    end else begin
      u_row = UNIT_RW'(cur_row_q);
      u_col = UNIT_CW'(cur_col_q);
    end
    u_lin  = LIN_W'(u_row) * LIN_W'(COLUMNS) + LIN_W'(u_col);
    u_addr = u_lin[AW-1:0];
  end

  // Memory port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = blank;
    mem_re    = 1'b0;
    mem_raddr = u_addr;
    if (wr_pend_q) begin
      mem_we    = 1'b1;
      mem_waddr = wr_addr_q;
      mem_wdata = rdata_q;
    end
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = RESET_CELL;
      end
      ST_BLANK: begin
        mem_we = 1'b1;
      end
      ST_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = u_addr;
        mem_wdata = {attr_q, req_q.char_code};
      end
      ST_BSW: begin
        mem_we    = 1'b1;
        mem_waddr = u_addr;
      end
      ST_RD, ST_BSR: begin
        mem_re = 1'b1;
      end
      ST_SCROLL: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(ptr_q + AW'(COLUMNS));
      end
      default: begin
      end
    endcase
  end

  // Screen memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    ptr_d     = ptr_q;
    cell_d    = cell_q;
    unique case (state_q)
      ST_CLEAR: begin
        ptr_d = AW'(ptr_q + AW'(1));
        if (ptr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cell_d = 16'h0000;
          if (req_i.kind == KIND_READ) begin
            if ((32'(req_i.read_row) < ROWS) && (32'(req_i.read_col) < COLUMNS)) begin
              state_d = ST_RD;
            end else begin
              state_d = ST_DONE;
            end
          end else if (req_i.char_code == CH_NEWLINE) begin
            state_d = ST_NL;
          end else if (req_i.char_code == CH_BACKSPACE) begin
            state_d = ST_BS;
          end else begin
            state_d = ST_PUT;
          end
        end
      end
      ST_RD: begin
        state_d = ST_RDW;
      end
      ST_RDW: begin
        cell_d  = rdata_q;
        state_d = ST_DONE;
      end
      ST_PUT: begin
        if (cur_col_q == CW'(COLUMNS - 1)) begin
          state_d = ST_NL;
        end else begin
          cur_col_d = cur_col_q + CW'(1);
          state_d   = ST_DONE;
        end
      end
      ST_NL: begin
        cur_col_d = '0;
        if (cur_row_q == RW'(ROWS - 1)) begin
          ptr_d   = '0;
          state_d = ST_SCROLL;
        end else begin
          cur_row_d = cur_row_q + RW'(1);
          state_d   = ST_DONE;
        end
      end
      ST_SCROLL: begin
        ptr_d = AW'(ptr_q + AW'(1));
        if (ptr_q == AW'(COPY_LAST)) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_d = ST_BLANK;
      end
      ST_BLANK: begin
        ptr_d = AW'(ptr_q + AW'(1));
        if (ptr_q == AW'(DEPTH - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_BS: begin
        if (cur_col_q != '0) begin
          cur_col_d = cur_col_q - CW'(1);
          state_d   = ST_BSW;
        end else begin
          if (cur_row_q != '0) begin
            cur_row_d = cur_row_q - RW'(1);
            cur_col_d = CW'(COLUMNS - 1);
          end
          state_d = ST_BSR;
        end
      end
      ST_BSR: begin
        state_d = ST_BSC;
      end
      ST_BSC: begin
        // Walk left over blank cells, then land just after the last used one (on it in the last column).
        if (cell_blank && (cur_col_q != '0)) begin
          cur_col_d = cur_col_q - CW'(1);
          state_d   = ST_BSR;
        end else begin
          if (!cell_blank && (cur_col_q != CW'(COLUMNS - 1))) begin
            cur_col_d = cur_col_q + CW'(1);
          end
          state_d = ST_BSW;
        end
      end
      ST_BSW: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      cur_row_q <= '0;
      cur_col_q <= '0;
      ptr_q     <= '0;
      wr_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_row_q <= cur_row_d;
      cur_col_q <= cur_col_d;
      ptr_q     <= ptr_d;
      wr_pend_q <= (state_q == ST_SCROLL);
    end
  end

  // Request payload, result cell and the delayed copy address.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    cell_q    <= cell_d;
    wr_addr_q <= ptr_q;
  end

  // Result channel.
  assign res_valid_o        = (state_q == ST_DONE);
  assign res_o.cursor_row   = 5'(cur_row_q);
  assign res_o.cursor_col   = 7'(cur_col_q);
  assign res_o.cursor_index = u_lin[10:0];
  assign res_o.cell_value   = cell_q;

  // Assertions.
  `ASSERT_ALWAYS(a_cursor_range, (cur_row_q < ROWS) && (cur_col_q < COLUMNS))
  `ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o)
  `ASSERT_NEXT(a_result_then_ready, res_valid_o, !busy_o)
  `ASSERT_IMPLIES(a_copy_in_scroll, wr_pend_q, (state_q == ST_SCROLL) || (state_q == ST_FLUSH))

endmodule
